// File: rtl/slr_pkg.sv
// shared types, constants and helpers for the least-squares line fit core
package slr_pkg;

  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int MUL_A_W    = 80;
  localparam int MUL_B_W    = 64;
  localparam int WIDE_W     = 128;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_X_EQUAL   = 2'd1;
  localparam logic [1:0] ST_TOO_FEW   = 2'd2;
  localparam logic [1:0] ST_TOO_MANY  = 2'd3;

  localparam logic [127:0] POS48 = 128'h7FFF_FFFF_FFFF;
  localparam logic [127:0] NEG48 = 128'h8000_0000_0000;
  localparam logic [127:0] MAX48 = 128'hFFFF_FFFF_FFFF;

  // snapshot of the running sums for one set of points
  typedef struct packed {
    logic [16:0] n;
    logic [32:0] sx;
    logic [32:0] sy;
    logic [46:0] sxx;
    logic [47:0] sxy;
    logic [46:0] syy;
    logic        ovf;
  } sums_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] slope;
    logic [47:0] intercept;
    logic [47:0] regression_ss;
    logic [47:0] residual_ss;
    logic [47:0] residual_var;
    logic [16:0] point_count;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
    logic                 neg;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_ISSUE, BK_WAIT, BK_EMIT
  } back_state_t;

  typedef enum logic [4:0] {
    OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY, OP_SYSXX, OP_SXSXY,
    OP_DEN, OP_UU, OP_NUM, OP_DEN2,
    OP_SLOPE, OP_ICPT, OP_RSS, OP_QSS, OP_VAR
  } op_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [47:0] sat_s48(input logic neg, input logic [127:0] m);
    logic [47:0] mm;
    if (neg) begin
      mm = (m > NEG48) ? NEG48[47:0] : m[47:0];
      sat_s48 = ~mm + 48'd1;
    end else begin
      sat_s48 = (m > POS48) ? POS48[47:0] : m[47:0];
    end
  endfunction

  function automatic logic [47:0] sat_u48(input logic [127:0] m);
    sat_u48 = (m > MAX48) ? MAX48[47:0] : m[47:0];
  endfunction

endpackage

// File: rtl/simple_linear_regression_core.sv
// top level of the least-squares line fit core
//
// channel  dir  tdata (low bit up)                          tlast
// s_axis   in   x_value[15:0], y_value[31:16]               last_point
// m_axis   out  status, slope, intercept, regression_ss,    -
//               residual_ss, residual_var, point_count, pad
//
// a point word is taken every cycle while the snapshot queue has room
// on a last point the sums go to a two-entry queue and the front restarts
// the back runs twelve shift-add products and five restoring divisions in turn,
// one operation at a time for each fit
// the result waits in an output register, so the back may start the next fit
// synchronous active-high reset clears sums, queue, sequencer and output valid
module simple_linear_regression_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // x_value, y_value
  input  logic         s_axis_tlast,   // last_point
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata    // status, slope, intercept, regression_ss,
                                       // residual_ss, residual_var, point_count
);
  import slr_pkg::*;

  sums_t push_data, pop_data;
  logic  push, pop, q_full, q_empty;
  res_t  res;

  // front stalls only when both queue slots hold unfinished fits
  assign s_axis_tready = !q_full;

  slr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .x_value    (s_axis_tdata[15:0]),
    .y_value    (s_axis_tdata[31:16]),
    .last_point (s_axis_tlast),
    .push       (push),
    .push_data  (push_data)
  );

  slr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  slr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // fields packed from the lowest bit, zero pad to whole bytes
  assign m_axis_tdata = {5'd0, res.point_count, res.residual_var, res.residual_ss,
                         res.regression_ss, res.intercept, res.slope, res.status};

endmodule

// File: rtl/slr_front.sv
// point accumulator: running sums, hands a snapshot to the queue on the last point
module slr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [15:0]   x_value,
  input  logic [15:0]   y_value,
  input  logic          last_point,
  output logic          push,
  output slr_pkg::sums_t push_data
);
  import slr_pkg::*;

  sums_t acc;
  sums_t acc_next;
  logic  accept;
  logic  room;
  logic signed [31:0] xx, yy, xy;

  assign accept = in_valid && in_ready;
  assign room   = acc.n < CNT_W'(MAX_POINTS);
  assign xx = $signed(x_value) * $signed(x_value);
  assign yy = $signed(y_value) * $signed(y_value);
  assign xy = $signed(x_value) * $signed(y_value);

  always_comb begin
    acc_next = acc;
    if (room) begin
      acc_next.n   = acc.n + 17'd1;
      acc_next.sx  = acc.sx + {{17{x_value[15]}}, x_value};
      acc_next.sy  = acc.sy + {{17{y_value[15]}}, y_value};
      acc_next.sxx = acc.sxx + {15'd0, xx};
      acc_next.syy = acc.syy + {15'd0, yy};
      acc_next.sxy = acc.sxy + {{16{xy[31]}}, xy};
    end else begin
      acc_next.ovf = 1'b1;
    end
  end

  assign push      = accept && last_point;
  assign push_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      acc <= '0;
    end else if (accept) begin
      acc <= acc_next;
    end
  end

endmodule

// File: rtl/slr_queue.sv
// two-entry queue of sum snapshots between front and back
module slr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slr_pkg::sums_t push_data,
  input  logic           pop,
  output slr_pkg::sums_t pop_data,
  output logic           full,
  output logic           empty
);
  import slr_pkg::*;

  sums_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// File: rtl/slr_mul.sv
// shift-add multiplier, one bit of b per cycle, optional negated product
module slr_mul (
  input  logic                clk,
  input  logic                rst,
  input  slr_pkg::mul_req_t   req,
  output logic                done,
  output logic [127:0]        prod
);
  import slr_pkg::*;

  logic [WIDE_W-1:0]  acc, aa;
  logic [MUL_B_W-1:0] bb;
  logic [6:0]         cnt;
  logic               busy, neg;

  assign prod = neg ? (~acc + 128'd1) : acc;

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      aa  <= WIDE_W'(req.a);
      bb  <= req.b;
      neg <= req.neg;
    end else if (busy) begin
      if (bb[0]) acc <= acc + aa;
      aa <= aa << 1;
      bb <= bb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'(MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/slr_div.sv
// restoring divider, one quotient bit per cycle, zero divisor gives zero
module slr_div (
  input  logic              clk,
  input  logic              rst,
  input  slr_pkg::div_req_t req,
  output logic              done,
  output logic [127:0]      quot
);
  import slr_pkg::*;

  logic [WIDE_W-1:0] rem, nn, q, d;
  logic [WIDE_W:0]   trial, shifted;
  logic [7:0]        cnt;
  logic              busy, dzero;

  assign shifted = {rem, nn[WIDE_W-1]};
  assign trial   = shifted - {1'b0, d};
  assign quot    = dzero ? '0 : q;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      nn    <= req.num;
      d     <= req.den;
      q     <= '0;
      dzero <= req.den == '0;
    end else if (busy) begin
      nn <= nn << 1;
      if (!trial[WIDE_W]) begin
        rem <= trial[WIDE_W-1:0];
        q   <= {q[WIDE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDE_W-1:0];
        q   <= {q[WIDE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 8'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 8'(WIDE_W);
      end else if (busy) begin
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/slr_back.sv
// fit sequencer: works one snapshot through the shared multiplier and divider
module slr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  slr_pkg::sums_t q_data,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output slr_pkg::res_t  res
);
  import slr_pkg::*;

  back_state_t state, state_next;
  op_t         op;
  mul_req_t    mreq;
  div_req_t    dreq;
  logic        mdone, ddone, is_div, step_done, load_res;
  logic [127:0] mprod, dquot, diff;

  sums_t        s;
  logic [127:0] tmp, im, den, u, num, den2;
  logic [63:0]  dxx, dyy, nmag, magsx, magsy, magsxy;
  logic         tneg, sneg, zx;
  logic [47:0]  slope, icpt, rss, qss, var_r;

  assign magsx  = mag64({{31{s.sx[32]}}, s.sx});
  assign magsy  = mag64({{31{s.sy[32]}}, s.sy});
  assign magsxy = mag64({{16{s.sxy[47]}}, s.sxy});
  assign is_div = op >= OP_SLOPE;
  assign step_done = is_div ? ddone : mdone;
  assign diff   = tmp - mprod;

  slr_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(mprod));
  slr_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot));

  // operand selection
  always_comb begin
    mreq = '0;
    dreq = '0;
    unique case (op)
      OP_NSXX:  begin mreq.a = 80'(s.sxx); mreq.b = 64'(s.n); end
      OP_SXSX:  begin mreq.a = 80'(magsx); mreq.b = magsx; end
      OP_NSYY:  begin mreq.a = 80'(s.syy); mreq.b = 64'(s.n); end
      OP_SYSY:  begin mreq.a = 80'(magsy); mreq.b = magsy; end
      OP_NSXY:  begin
        mreq.a = 80'(magsxy); mreq.b = 64'(s.n); mreq.neg = s.sxy[47];
      end
      OP_SXSY:  begin
        mreq.a = 80'(magsx); mreq.b = magsy; mreq.neg = s.sx[32] ^ s.sy[32];
      end
      OP_SYSXX: begin mreq.a = 80'(s.sxx); mreq.b = magsy; mreq.neg = s.sy[32]; end
      OP_SXSXY: begin
        mreq.a = 80'(magsxy); mreq.b = magsx; mreq.neg = s.sx[32] ^ s.sxy[47];
      end
      OP_DEN:   begin mreq.a = 80'(dxx); mreq.b = 64'(s.n); end
      OP_UU:    begin mreq.a = 80'(nmag); mreq.b = nmag; end
      OP_NUM:   begin mreq.a = 80'(dyy); mreq.b = dxx; end
      OP_DEN2:  begin mreq.a = den[79:0]; mreq.b = 64'(s.n) - 64'd2; end
      OP_SLOPE: begin dreq.num = 128'(nmag) << 16; dreq.den = 128'(dxx); end
      OP_ICPT:  begin
        if (zx) begin
          dreq.num = 128'(magsy) << 16; dreq.den = 128'(s.n);
        end else begin
          dreq.num = im << 16; dreq.den = 128'(dxx);
        end
      end
      OP_RSS:   begin dreq.num = u;   dreq.den = den;  end
      OP_QSS:   begin dreq.num = num; dreq.den = den;  end
      OP_VAR:   begin dreq.num = num; dreq.den = den2; end
      default:  begin end
    endcase
    mreq.start = (state == BK_ISSUE) && !is_div;
    dreq.start = (state == BK_ISSUE) && is_div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_ISSUE;
        end
      end
      BK_ISSUE: state_next = BK_WAIT;
      BK_WAIT: begin
        if (step_done) state_next = (op == OP_VAR) ? BK_EMIT : BK_ISSUE;
      end
      BK_EMIT: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_NSXX;
    end else if (pop) begin
      op <= OP_NSXX;
    end else if (state == BK_WAIT && step_done && op != OP_VAR) begin
      op <= op_t'(op + 5'd1);
    end
  end

  // step results
  always_ff @(posedge clk) begin
    if (pop) begin
      s  <= q_data;
      zx <= 1'b0;
    end else if (state == BK_WAIT && step_done) begin
      case (op) inside
        OP_NSXX, OP_NSYY, OP_NSXY, OP_SYSXX: tmp <= mprod;
        OP_SXSX: dxx <= diff[63:0];
        OP_SYSY: dyy <= diff[63:0];
        OP_SXSY: begin
          if (dxx == '0) begin
            zx   <= 1'b1;
            dxx  <= 64'd1;
            nmag <= '0;
            tneg <= 1'b0;
          end else begin
            tneg <= diff[127];
            nmag <= mag64(diff[63:0]);
          end
        end
        OP_SXSXY: begin
          sneg <= diff[127];
          im   <= diff[127] ? (~diff + 128'd1) : diff;
        end
        OP_DEN:   den  <= mprod;
        OP_UU:    u    <= mprod;
        OP_NUM:   num  <= (mprod < u) ? '0 : (mprod - u);
        OP_DEN2:  den2 <= mprod;
        OP_SLOPE: slope <= sat_s48(tneg && (nmag != '0), dquot);
        OP_ICPT:  icpt  <= sat_s48(zx ? s.sy[32] : sneg, dquot);
        OP_RSS:   rss   <= sat_u48(dquot);
        OP_QSS:   qss   <= sat_u48(dquot);
        OP_VAR:   var_r <= (s.n >= 17'd3) ? sat_u48(dquot) : '0;
        default: begin end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      if (s.ovf)             res.status <= ST_TOO_MANY;
      else if (zx)           res.status <= ST_X_EQUAL;
      else if (s.n < 17'd3)  res.status <= ST_TOO_FEW;
      else                   res.status <= ST_OK;
      res.slope         <= slope;
      res.intercept     <= icpt;
      res.regression_ss <= rss;
      res.residual_ss   <= qss;
      res.residual_var  <= var_r;
      res.point_count   <= s.n;
    end
  end

endmodule
